[hdl/rsh_pkg.sv]
package rsh_pkg;

	// Field widths of the interface.
	localparam int unsigned COORD_W  = 16;
	localparam int unsigned RADIUS_W = 15;
	localparam int unsigned INDEX_W  = 8;

	// Internal widths, sized to the largest magnitude each value can reach.
	localparam int unsigned L_W    = COORD_W + 1;  // center minus origin
	localparam int unsigned DOT_W  = 35;           // signed L.D
	localparam int unsigned LL_W   = 34;           // L.L
	localparam int unsigned DD_W   = 32;           // D.D
	localparam int unsigned RR_W   = 2 * RADIUS_W; // r^2
	localparam int unsigned HALF_W = 17;           // partial product split
	localparam int unsigned ACC_W  = 68;           // final comparison width

	// Configuration register indexes.
	localparam logic [INDEX_W-1:0] REG_CENTER_X = 8'd0;
	localparam logic [INDEX_W-1:0] REG_CENTER_Y = 8'd1;
	localparam logic [INDEX_W-1:0] REG_CENTER_Z = 8'd2;
	localparam logic [INDEX_W-1:0] REG_RADIUS   = 8'd3;

	typedef struct packed {
		logic signed [COORD_W-1:0] center_x;
		logic signed [COORD_W-1:0] center_y;
		logic signed [COORD_W-1:0] center_z;
		logic [RADIUS_W-1:0]       sphere_radius;
	} sphere_cfg_t;

endpackage

[hdl/ray_sphere_hit_test.sv]
// Channel   Direction  Handshake                 Payload
// -------   ---------  ------------------------  -------------------------------------
// input     in         in_valid / in_stall       origin_x/y/z, dir_x/y/z (Q8.8 signed)
// output    out        out_valid / out_stall     hit
// config    in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One ray request is accepted every clock while in_stall is low. Each request
// passes through the six-stage arithmetic pipeline in rsh_core, and out_valid
// is the valid bit of its last stage.
// Reset clears every pipeline valid bit and the sphere registers to zero.
// A stall on the output holds the last stage; earlier stages keep filling
// bubbles, and in_stall rises only once every stage holds a request.
// The configuration port is always ready and takes one write per clock.
module ray_sphere_hit_test (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write channel.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rsh_pkg::INDEX_W-1:0]         cfg_index,
	input  logic [rsh_pkg::COORD_W-1:0]         cfg_data,
	// Ray input channel.
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [rsh_pkg::COORD_W-1:0]  origin_x,
	input  logic signed [rsh_pkg::COORD_W-1:0]  origin_y,
	input  logic signed [rsh_pkg::COORD_W-1:0]  origin_z,
	input  logic signed [rsh_pkg::COORD_W-1:0]  dir_x,
	input  logic signed [rsh_pkg::COORD_W-1:0]  dir_y,
	input  logic signed [rsh_pkg::COORD_W-1:0]  dir_z,
	// Hit result channel.
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                hit
);
	import rsh_pkg::*;

	sphere_cfg_t cfg_q;

	// The register file never needs to back-pressure a write.
	assign cfg_ready = 1'b1;

	// Writes to indexes beyond the radius register are dropped. The radius
	// keeps only its low fifteen bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CENTER_X: cfg_q.center_x      <= cfg_data;
				REG_CENTER_Y: cfg_q.center_y      <= cfg_data;
				REG_CENTER_Z: cfg_q.center_z      <= cfg_data;
				REG_RADIUS:   cfg_q.sphere_radius <= cfg_data[RADIUS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The datapath evaluates L.D >= 0 and (L.L)(D.D) - (L.D)^2 <= r^2 (D.D)
	// exactly, with a zero direction reported as a miss.
	rsh_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.origin_x  (origin_x),
		.origin_y  (origin_y),
		.origin_z  (origin_z),
		.dir_x     (dir_x),
		.dir_y     (dir_y),
		.dir_z     (dir_z),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hit       (hit)
	);

endmodule

[hdl/rsh_core.sv]
module rsh_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rsh_pkg::sphere_cfg_t              cfg,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [rsh_pkg::COORD_W-1:0] origin_x,
	input  logic signed [rsh_pkg::COORD_W-1:0] origin_y,
	input  logic signed [rsh_pkg::COORD_W-1:0] origin_z,
	input  logic signed [rsh_pkg::COORD_W-1:0] dir_x,
	input  logic signed [rsh_pkg::COORD_W-1:0] dir_y,
	input  logic signed [rsh_pkg::COORD_W-1:0] dir_z,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              hit
);
	import rsh_pkg::*;

	// Stage load enables: a stage loads when it is empty or its successor loads.
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	assign en_s6 = !v_s6 || !out_stall;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign in_stall  = !en_s1;
	assign out_valid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	// Stage 1: vector from the ray origin to the sphere center.
	logic signed [L_W-1:0]     lx_s1, ly_s1, lz_s1;
	logic signed [COORD_W-1:0] dx_s1, dy_s1, dz_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			lx_s1 <= L_W'(cfg.center_x) - L_W'(origin_x);
			ly_s1 <= L_W'(cfg.center_y) - L_W'(origin_y);
			lz_s1 <= L_W'(cfg.center_z) - L_W'(origin_z);
			dx_s1 <= dir_x;
			dy_s1 <= dir_y;
			dz_s1 <= dir_z;
		end
	end

	// Stage 2: the nine component products and the squared radius.
	logic signed [L_W+COORD_W-1:0] ld_x_s2, ld_y_s2, ld_z_s2;
	logic [2*COORD_W-1:0]          ll_x_s2, ll_y_s2, ll_z_s2;
	logic [2*COORD_W-2:0]          dd_x_s2, dd_y_s2, dd_z_s2;
	logic [RR_W-1:0]               rr_s2;
	logic signed [2*L_W-1:0]       sq_lx, sq_ly, sq_lz;
	logic signed [2*COORD_W-1:0]   sq_dx, sq_dy, sq_dz;

	assign sq_lx = lx_s1 * lx_s1;
	assign sq_ly = ly_s1 * ly_s1;
	assign sq_lz = lz_s1 * lz_s1;
	assign sq_dx = dx_s1 * dx_s1;
	assign sq_dy = dy_s1 * dy_s1;
	assign sq_dz = dz_s1 * dz_s1;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			ld_x_s2 <= (L_W+COORD_W)'(lx_s1) * (L_W+COORD_W)'(dx_s1);
			ld_y_s2 <= (L_W+COORD_W)'(ly_s1) * (L_W+COORD_W)'(dy_s1);
			ld_z_s2 <= (L_W+COORD_W)'(lz_s1) * (L_W+COORD_W)'(dz_s1);
			// Squares of L stay below 2^32, those of D are at most 2^30.
			ll_x_s2 <= sq_lx[2*COORD_W-1:0];
			ll_y_s2 <= sq_ly[2*COORD_W-1:0];
			ll_z_s2 <= sq_lz[2*COORD_W-1:0];
			dd_x_s2 <= sq_dx[2*COORD_W-2:0];
			dd_y_s2 <= sq_dy[2*COORD_W-2:0];
			dd_z_s2 <= sq_dz[2*COORD_W-2:0];
			rr_s2   <= RR_W'(cfg.sphere_radius) * RR_W'(cfg.sphere_radius);
		end
	end

	// Stage 3: the three dot products.
	logic signed [DOT_W-1:0] ld_s3;
	logic [LL_W-1:0]         ll_s3;
	logic [DD_W-1:0]         dd_s3;
	logic [RR_W-1:0]         rr_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			ld_s3 <= DOT_W'(ld_x_s2) + DOT_W'(ld_y_s2) + DOT_W'(ld_z_s2);
			ll_s3 <= LL_W'(ll_x_s2) + LL_W'(ll_y_s2) + LL_W'(ll_z_s2);
			dd_s3 <= DD_W'(dd_x_s2) + DD_W'(dd_y_s2) + DD_W'(dd_z_s2);
			rr_s3 <= rr_s2;
		end
	end

	// Stage 4: partial products of the wide terms, split in 17-bit halves.
	logic [2*HALF_W-1:0]        ldm;
	logic [HALF_W+DD_W-1:0]     lhs_lo_s4, lhs_hi_s4;
	logic [2*HALF_W-1:0]        ld_ll_s4, ld_lh_s4, ld_hh_s4;
	logic [RR_W+DD_W-1:0]       rdd_s4;
	logic                       miss_s4;

	// Only used when L.D is not negative, so its low bits are the magnitude.
	assign ldm = (2*HALF_W)'(ld_s3[DOT_W-3:0]);

	always_ff @(posedge clk) begin
		if (en_s4) begin
			lhs_lo_s4 <= (HALF_W+DD_W)'(ll_s3[HALF_W-1:0]) * (HALF_W+DD_W)'(dd_s3);
			lhs_hi_s4 <= (HALF_W+DD_W)'(ll_s3[LL_W-1:HALF_W]) * (HALF_W+DD_W)'(dd_s3);
			ld_ll_s4  <= (2*HALF_W)'(ldm[HALF_W-1:0]) * (2*HALF_W)'(ldm[HALF_W-1:0]);
			ld_lh_s4  <= (2*HALF_W)'(ldm[HALF_W-1:0]) * (2*HALF_W)'(ldm[2*HALF_W-1:HALF_W]);
			ld_hh_s4  <= (2*HALF_W)'(ldm[2*HALF_W-1:HALF_W])
			           * (2*HALF_W)'(ldm[2*HALF_W-1:HALF_W]);
			rdd_s4    <= (RR_W+DD_W)'(rr_s3) * (RR_W+DD_W)'(dd_s3);
			miss_s4   <= (dd_s3 == '0) || ld_s3[DOT_W-1];
		end
	end

	// Stage 5: recombine into both sides of the distance test.
	logic [ACC_W-1:0] lhs_s5, rhs_s5;
	logic             miss_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			lhs_s5  <= (ACC_W'(lhs_hi_s4) << HALF_W) + ACC_W'(lhs_lo_s4);
			rhs_s5  <= (ACC_W'(ld_hh_s4) << (2*HALF_W)) + (ACC_W'(ld_lh_s4) << (HALF_W+1))
			         + ACC_W'(ld_ll_s4) + ACC_W'(rdd_s4);
			miss_s5 <= miss_s4;
		end
	end

	// Stage 6: compare and hold the result for the consumer.
	logic hit_s6;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			hit_s6 <= !miss_s5 && (lhs_s5 <= rhs_s5);
		end
	end

	assign hit = hit_s6;

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

// Self-checking bench for the ray/sphere hit test.
//
// Each ray request that the block accepts is run through a predictor in this bench.
// The predictor evaluates the exact fixed-point form of the test:
//   L = C - O, miss when D is zero or L.D < 0,
//   otherwise hit when (L.L)(D.D) - (L.D)^2 <= r^2 (D.D).
// The predicted hit bit goes into a FIFO, and every result that the block delivers
// is compared with the oldest entry. Sphere registers are only rewritten once the
// FIFO has drained, so that no request is in flight while the sphere moves.
//
// Stimulus is split into tests:
// - A directed part: reset defaults, hand-placed geometry, register masking and
//   the extreme coordinates.
// - Random phases: each one works through several sphere settings, and each phase
//   sets its own idle rates for the sender and receiver.
// - A back-pressure test: the receiver holds off for a long stretch until the
//   pipeline fills and the block stalls its input.
module tb;
	import rsh_pkg::*;

	localparam int CLK_PERIOD       = 10;
	localparam int TIMEOUT_NS       = 2_000_000;
	localparam int MAX_REPORTS      = 10;
	// The pipeline is six deep, and the settle wait after the drain catches any straggler.
	localparam int SETTLE_CYCLES    = 12;
	localparam int ITEMS_PER_SPHERE = 110;
	localparam int SPHERES_PER_RUN  = 4;
	localparam int HOLD_CYCLES      = 80;
	localparam int HOLD_RAYS        = 40;
	// One in Q8.8.
	localparam int Q_ONE            = 256;
	localparam int COORD_MAX        = 32767;
	localparam int COORD_MIN        = -32768;
	localparam int RADIUS_MAX       = 32767;

	// Register indexes that the block does not implement. Writes to them must be dropped.
	localparam logic [INDEX_W-1:0] REG_SPARE = 8'd4;
	localparam logic [INDEX_W-1:0] REG_TOP   = 8'hFF;

	typedef struct packed {
		logic signed [COORD_W-1:0] origin_x;
		logic signed [COORD_W-1:0] origin_y;
		logic signed [COORD_W-1:0] origin_z;
		logic signed [COORD_W-1:0] dir_x;
		logic signed [COORD_W-1:0] dir_y;
		logic signed [COORD_W-1:0] dir_z;
	} ray_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [INDEX_W-1:0] cfg_index = '0;
	logic [COORD_W-1:0] cfg_data = '0;

	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [COORD_W-1:0] origin_x = '0;
	logic signed [COORD_W-1:0] origin_y = '0;
	logic signed [COORD_W-1:0] origin_z = '0;
	logic signed [COORD_W-1:0] dir_x = '0;
	logic signed [COORD_W-1:0] dir_y = '0;
	logic signed [COORD_W-1:0] dir_z = '0;

	logic out_valid;
	logic out_stall = 1'b0;
	logic hit;

	// The bench's own copy of the sphere registers. It is updated as each write is accepted.
	sphere_cfg_t sphere = '0;

	// Predicted hit bits, oldest first.
	bit pending_hits[$];

	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	// The test body bumps hold_token to ask for a receiver hold-off.
	// The stall process counts the hold-off down on its own.
	int hold_token = 0;
	int hold_seen = 0;
	int hold_left = 0;

	int rays_sent = 0;
	int results_seen = 0;
	int hits_seen = 0;
	int sphere_writes = 0;
	int input_stall_cycles = 0;
	int mismatches = 0;
	int errors = 0;

	ray_sphere_hit_test dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.origin_x  (origin_x),
		.origin_y  (origin_y),
		.origin_z  (origin_z),
		.dir_x     (dir_x),
		.dir_y     (dir_y),
		.dir_z     (dir_z),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hit       (hit)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Hard stop in case the block locks up or stops draining.
	initial begin
		#(TIMEOUT_NS);
		$display("Timeout after %0d ns with %0d results outstanding", TIMEOUT_NS,
			pending_hits.size());
		$display("Simulation FAILED");
		$finish;
	end

	// Exact hit test. The wide products are formed at 128 bits, so nothing overflows.
	// L.L*D.D stays below 2^68, and so does the right-hand side.
	function automatic bit ray_hits_sphere(sphere_cfg_t s, ray_t r);
		longint lx, ly, lz, dx, dy, dz;
		longint l_dot_d, l_len2, d_len2, rad;
		logic [127:0] off_axis, on_axis;
		lx = longint'($signed(s.center_x)) - longint'($signed(r.origin_x));
		ly = longint'($signed(s.center_y)) - longint'($signed(r.origin_y));
		lz = longint'($signed(s.center_z)) - longint'($signed(r.origin_z));
		dx = longint'($signed(r.dir_x));
		dy = longint'($signed(r.dir_y));
		dz = longint'($signed(r.dir_z));
		rad = longint'(s.sphere_radius);
		l_dot_d = lx * dx + ly * dy + lz * dz;
		l_len2 = lx * lx + ly * ly + lz * lz;
		d_len2 = dx * dx + dy * dy + dz * dz;
		// A zero direction has no ray at all. A negative L.D puts the sphere behind the origin.
		if (d_len2 == 0 || l_dot_d < 0)
			return 1'b0;
		off_axis = 128'(l_len2) * 128'(d_len2);
		on_axis = 128'(l_dot_d) * 128'(l_dot_d) + 128'(rad * rad) * 128'(d_len2);
		// Equality is a tangent ray, and it counts as a hit.
		return off_axis <= on_axis;
	endfunction

	function automatic ray_t mk_ray(int ox, int oy, int oz, int dx, int dy, int dz);
		ray_t r;
		r.origin_x = ox[COORD_W-1:0];
		r.origin_y = oy[COORD_W-1:0];
		r.origin_z = oz[COORD_W-1:0];
		r.dir_x = dx[COORD_W-1:0];
		r.dir_y = dy[COORD_W-1:0];
		r.dir_z = dz[COORD_W-1:0];
		return r;
	endfunction

	function automatic int clamp_coord(int v);
		if (v > COORD_MAX)
			return COORD_MAX;
		if (v < COORD_MIN)
			return COORD_MIN;
		return v;
	endfunction

	// Most random rays are aimed at the sphere, so that hits, near misses and grazing
	// rays are common. The origin sits a whole number of direction steps from the
	// centre, and a jitter about the size of the radius is added. A negative step
	// count puts the sphere behind the origin. The remaining rays use raw 16-bit
	// values, so that every bit of every field toggles.
	function automatic ray_t random_ray();
		int dx, dy, dz, steps, jitter;
		if ($urandom_range(99) < 30)
			return ray_t'({$urandom(), $urandom(), $urandom()});
		dx = int'($urandom_range(4096)) - 2048;
		dy = int'($urandom_range(4096)) - 2048;
		dz = int'($urandom_range(4096)) - 2048;
		steps = int'($urandom_range(8)) - 2;
		jitter = int'(sphere.sphere_radius) + 1;
		return mk_ray(
			clamp_coord(int'($signed(sphere.center_x)) - steps * dx
				+ int'($urandom_range(2 * jitter)) - jitter),
			clamp_coord(int'($signed(sphere.center_y)) - steps * dy
				+ int'($urandom_range(2 * jitter)) - jitter),
			clamp_coord(int'($signed(sphere.center_z)) - steps * dz
				+ int'($urandom_range(2 * jitter)) - jitter),
			dx, dy, dz);
	endfunction

	// One configuration write. The model follows the block's decode: unknown indexes are
	// dropped, and the radius keeps only its low 15 bits. After each write the bench
	// lowers cfg_valid and waits on the clock, so that cfg_valid is never lowered and
	// raised again in the same step.
	task automatic write_reg(logic [INDEX_W-1:0] index, logic [COORD_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (index)
			REG_CENTER_X: sphere.center_x = data;
			REG_CENTER_Y: sphere.center_y = data;
			REG_CENTER_Z: sphere.center_z = data;
			REG_RADIUS:   sphere.sphere_radius = data[RADIUS_W-1:0];
			default:      ;
		endcase
		sphere_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_sphere(int cx, int cy, int cz, int radius);
		write_reg(REG_CENTER_X, cx[COORD_W-1:0]);
		write_reg(REG_CENTER_Y, cy[COORD_W-1:0]);
		write_reg(REG_CENTER_Z, cz[COORD_W-1:0]);
		write_reg(REG_RADIUS, radius[COORD_W-1:0]);
	endtask

	// Offer one ray request, after a random number of idle cycles, and hold it until
	// it is accepted. On return, valid is still high. The next call either keeps it
	// high with a new payload or drops it for a gap.
	task automatic send_ray(ray_t r);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		origin_x <= r.origin_x;
		origin_y <= r.origin_y;
		origin_z <= r.origin_z;
		dir_x <= r.dir_x;
		dir_y <= r.dir_y;
		dir_z <= r.dir_z;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_hits.push_back(ray_hits_sphere(sphere, r));
		rays_sent++;
	endtask

	// Stop offering requests and wait until every predicted result has come back.
	// The block is idle after that.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_hits.size() != 0)
			@(posedge clk);
	endtask

	// Receiver side. A requested hold-off takes priority. Otherwise the receiver stalls
	// at the current idle rate.
	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < sink_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_stall)
			input_stall_cycles++;
	end

	// Result checker. It compares each delivered result with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (hit === 1'b1)
				hits_seen++;
			if (pending_hits.size() == 0) begin
				errors++;
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result %0d arrived with no ray outstanding (hit=%b)",
						$realtime, results_seen, hit);
			end else if (hit !== pending_hits[0]) begin
				errors++;
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result %0d hit mismatch, expected %b, got %b",
						$realtime, results_seen, pending_hits[0], hit);
				void'(pending_hits.pop_front());
			end else begin
				void'(pending_hits.pop_front());
			end
		end
	end

	// The registers still hold their reset values: the sphere is a point at the origin.
	// Only a ray whose line runs exactly through that point, pointing at it, reports a hit.
	task automatic test_reset_values();
		send_ray(mk_ray(-Q_ONE, 0, 0, Q_ONE, 0, 0));
		send_ray(mk_ray(-Q_ONE, 1, 0, Q_ONE, 0, 0));
		send_ray(mk_ray(-Q_ONE, 0, 0, 0, 0, 0));
		drain();
	endtask

	// Hand-placed rays against a sphere at x = 10.0 with radius 2.0.
	task automatic test_directed_geometry();
		set_sphere(10 * Q_ONE, 0, 0, 2 * Q_ONE);
		// This ray is aimed straight at the centre.
		send_ray(mk_ray(0, 0, 0, Q_ONE, 0, 0));
		// This one points away, so the sphere lies behind its origin.
		send_ray(mk_ray(0, 0, 0, -Q_ONE, 0, 0));
		// This one grazes the top of the sphere. The equality counts as a hit.
		send_ray(mk_ray(0, 2 * Q_ONE, 0, Q_ONE, 0, 0));
		// One LSB higher, the ray misses.
		send_ray(mk_ray(0, 2 * Q_ONE + 1, 0, Q_ONE, 0, 0));
		// This origin sits on the centre. L is zero, so any direction hits.
		send_ray(mk_ray(10 * Q_ONE, 0, 0, -3, 7, 1));
		// These origins are inside the sphere. The ray still misses when the centre is
		// behind its origin.
		send_ray(mk_ray(9 * Q_ONE, 0, 0, Q_ONE, 0, 0));
		send_ray(mk_ray(11 * Q_ONE, 0, 0, Q_ONE, 0, 0));
		// A zero direction is always a miss, even when the origin is inside the sphere.
		send_ray(mk_ray(10 * Q_ONE, Q_ONE, 0, 0, 0, 0));
		drain();
		// A zero radius leaves only rays that pass exactly through the centre.
		write_reg(REG_RADIUS, '0);
		send_ray(mk_ray(0, 0, 0, 5 * Q_ONE, 0, 0));
		send_ray(mk_ray(0, 1, 0, 5 * Q_ONE, 0, 0));
		drain();
	endtask

	// Writes to indexes the block does not implement must leave the sphere alone.
	// Radius bit 15 must be ignored.
	task automatic test_register_masking();
		set_sphere(10 * Q_ONE, 0, 0, 2 * Q_ONE);
		write_reg(REG_SPARE, 16'h1234);
		write_reg(REG_TOP, 16'hFFFF);
		write_reg(REG_RADIUS, 16'h8000 | 16'(2 * Q_ONE));
		send_ray(mk_ray(0, 2 * Q_ONE, 0, Q_ONE, 0, 0));
		send_ray(mk_ray(0, 2 * Q_ONE + 1, 0, Q_ONE, 0, 0));
		drain();
		// An all-ones write gives the largest radius, 127.996.
		write_reg(REG_RADIUS, 16'hFFFF);
		send_ray(mk_ray(0, 100 * Q_ONE, 0, Q_ONE, 0, 0));
		drain();
	endtask

	// The corner cases: coordinates at both ends of the Q8.8 range, with the largest
	// and the smallest radius.
	task automatic test_extremes();
		set_sphere(COORD_MIN, COORD_MIN, COORD_MIN, RADIUS_MAX);
		send_ray(mk_ray(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
		send_ray(mk_ray(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
		send_ray(mk_ray(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
		drain();
		// Here L and D are exactly parallel. The off-axis distance is zero, so even a zero
		// radius reports a hit. Tilting D by one LSB turns the ray into a miss.
		set_sphere(COORD_MAX, COORD_MAX, COORD_MAX, 0);
		send_ray(mk_ray(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
		send_ray(mk_ray(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
			COORD_MAX - 1));
		send_ray(mk_ray(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
		drain();
	endtask

	// One random phase. The sphere is moved several times: a random sphere, a small
	// sphere near the origin, and the two extreme corners. Each sphere gets a batch
	// of random rays.
	task automatic test_random(int src_pct, int sink_pct);
		int n, i;
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
		for (n = 0; n < SPHERES_PER_RUN; n++) begin
			drain();
			case (n)
				0: set_sphere(int'($urandom_range(65535)) - 32768,
					int'($urandom_range(65535)) - 32768,
					int'($urandom_range(65535)) - 32768, int'($urandom_range(RADIUS_MAX)));
				1: set_sphere(int'($urandom_range(8192)) - 4096,
					int'($urandom_range(8192)) - 4096,
					int'($urandom_range(8192)) - 4096, int'($urandom_range(16 * Q_ONE)));
				2: set_sphere(COORD_MAX, COORD_MAX, COORD_MAX, RADIUS_MAX);
				default: set_sphere(COORD_MIN, COORD_MIN, COORD_MIN, 0);
			endcase
			for (i = 0; i < ITEMS_PER_SPHERE; i++)
				send_ray(random_ray());
		end
		drain();
	endtask

	// The receiver holds off while the sender keeps offering requests back to back.
	// The pipeline fills, and the block has to raise in_stall and keep the waiting
	// request intact.
	task automatic test_backpressure();
		int i;
		src_idle_pct = 0;
		sink_idle_pct = 0;
		set_sphere(2 * Q_ONE, -3 * Q_ONE, Q_ONE, 4 * Q_ONE);
		hold_token++;
		for (i = 0; i < HOLD_RAYS; i++)
			send_ray(random_ray());
		drain();
	endtask

	initial begin
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_directed_geometry();
		test_register_masking();
		test_extremes();
		test_random(21, 54);
		test_random(54, 21);
		test_random(0, 0);
		test_backpressure();

		drain();
		repeat (SETTLE_CYCLES)
			@(posedge clk);

		$display("Checked %0d hit results for %0d rays (%0d hits, %0d mismatches)",
			results_seen, rays_sent, hits_seen, mismatches);
		$display("Made %0d sphere register writes; input was held off for %0d cycles",
			sphere_writes, input_stall_cycles);
		if (errors == 0 && pending_hits.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d results never arrived", pending_hits.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

[filelist.f]
hdl/rsh_pkg.sv
hdl/rsh_core.sv
hdl/ray_sphere_hit_test.sv
test/tb.sv
